// ===== hdl/dhr_pkg.sv =====
// ----------------------------------------------------------------------------
// dhr_pkg: shared types and constants
// Holds the item record, the fixed color palette and the field widths for the
// double hi-res pixel serializer.
// ----------------------------------------------------------------------------
package dhr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLOR_W  = 9;
  localparam int unsigned REP_W    = 3;
  localparam int unsigned ACC_W    = 21;  // pending bits plus one column
  localparam int unsigned LEFT_W   = 7;   // at most seven bits carry over
  localparam int unsigned CNT_W    = 3;   // 0..7 pending bits
  localparam int unsigned WORDS_W  = 3;   // 1..7 words per item

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 9'h1ff;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 9'h000;
  localparam logic [REP_W-1:0]   REP_COLOR   = 3'd4;
  localparam logic [REP_W-1:0]   REP_MONO    = 3'd1;
  localparam logic [WORDS_W-1:0] WORDS_MONO  = 3'd7;

  // Item handed from the accumulator to the word emitter.
  typedef struct packed {
    logic [ACC_W-1:0]   bits;   // oldest bit in bit 0
    logic [WORDS_W-1:0] words;  // words to emit
    logic               mono;   // mode latched with the item
  } item_t;

  // 16-entry RGB333 palette.
  function automatic logic [COLOR_W-1:0] palette(input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    unique case (idx)
      4'h0:    c = 9'h000;
      4'h1:    c = 9'h005;
      4'h2:    c = 9'h020;
      4'h3:    c = 9'h01e;
      4'h4:    c = 9'h0d8;
      4'h5:    c = 9'h124;
      4'h6:    c = 9'h031;
      4'h7:    c = 9'h13c;
      4'h8:    c = 9'h183;
      4'h9:    c = 9'h14f;
      4'ha:    c = 9'h092;
      4'hb:    c = 9'h0df;
      4'hc:    c = 9'h1d9;
      4'hd:    c = 9'h1f7;
      4'he:    c = 9'h1b0;
      default: c = 9'h1ff;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/dhr_if.sv =====
// ----------------------------------------------------------------------------
// dhr_in_if / dhr_out_if: valid/ready channels
// Column channel into the serializer and word channel out of it.
// ----------------------------------------------------------------------------
interface dhr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] aux_byte;
  logic [7:0] main_byte;
  logic       line_start;

  modport source (output valid, aux_byte, main_byte, line_start, input ready);
  modport sink   (input valid, aux_byte, main_byte, line_start, output ready);
endinterface

interface dhr_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] first_color;
  logic [8:0] second_color;
  logic [2:0] repeat_each;
  logic       last_of_item;

  modport source (output valid, first_color, second_color, repeat_each, last_of_item,
                  input ready);
  modport sink   (input valid, first_color, second_color, repeat_each, last_of_item,
                  output ready);
endinterface

// ===== hdl/dhr_accum.sv =====
// ----------------------------------------------------------------------------
// dhr_accum: column bit accumulator
// Appends 14 bits per column to the pending bits, works out how many words the
// column yields and keeps the leftover bits for the next column.
// ----------------------------------------------------------------------------
module dhr_accum
  import dhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  dhr_in_if.sink      in_ch,
  input  logic        load_ok,
  output logic        item_v,
  output item_t       item
);

  logic              mono_r;
  logic [LEFT_W-1:0] left_bits_r, left_bits_nxt;
  logic [CNT_W-1:0]  left_cnt_r,  left_cnt_nxt;

  logic              accept;
  logic [LEFT_W-1:0] base_bits;
  logic [CNT_W-1:0]  base_cnt;
  logic [13:0]       fresh;
  logic [ACC_W-1:0]  total_bits;
  logic [4:0]        total_cnt;

  assign in_ch.ready = load_ok;
  assign accept      = in_ch.valid & load_ok;

  always_comb begin
    base_bits  = in_ch.line_start ? '0 : left_bits_r;
    base_cnt   = in_ch.line_start ? '0 : left_cnt_r;
    fresh      = {in_ch.main_byte[6:0], in_ch.aux_byte[6:0]};
    total_bits = {14'b0, base_bits} | ({7'b0, fresh} << base_cnt);
    total_cnt  = {2'b0, base_cnt} + 5'd14;

    item.bits = total_bits;
    item.mono = mono_r;
    if (mono_r) begin
      // 14..21 bits always give seven 2-bit words; base_cnt bits remain
      item.words    = WORDS_MONO;
      left_bits_nxt = total_bits[20:14];
      left_cnt_nxt  = base_cnt;
    end else if (total_cnt >= 5'd16) begin
      item.words    = 3'd2;
      left_bits_nxt = {2'b0, total_bits[20:16]};
      left_cnt_nxt  = total_cnt[CNT_W-1:0];          // total - 16
    end else begin
      item.words    = 3'd1;
      left_bits_nxt = total_bits[14:8];
      left_cnt_nxt  = 3'(total_cnt - 5'd8);
    end
  end

  assign item_v = accept & (item.words != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r      <= 1'b0;
      left_bits_r <= '0;
      left_cnt_r  <= '0;
    end else begin
      if (cfg_we) mono_r <= cfg_wdata;
      if (accept) begin
        left_bits_r <= left_bits_nxt;
        left_cnt_r  <= left_cnt_nxt;
      end
    end
  end

  a_mono_seven: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v && item.mono) |-> (item.words == WORDS_MONO))
    else $error("mono item must yield seven words");

  a_color_words: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v && !item.mono) |-> (item.words == 3'd1 || item.words == 3'd2))
    else $error("color item must yield one or two words");

  a_left_clean: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((left_bits_r >> left_cnt_r) == '0))
    else $error("stale bits above pending count");

endmodule

// ===== hdl/dhr_emit.sv =====
// ----------------------------------------------------------------------------
// dhr_emit: word emitter
// Holds one item and sends its words one per cycle, while out_ch is not stalled,
// into the output register, mapping bits to colors on the way.
// ----------------------------------------------------------------------------
module dhr_emit
  import dhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_v,
  input  item_t       item,
  output logic        load_ok,
  dhr_out_if.source   out_ch
);

  logic                ivalid_r;
  logic [ACC_W-1:0]    ibits_r, ibits_nxt;
  logic [WORDS_W-1:0]  irem_r;
  logic                imono_r;

  logic                ovalid_r;
  logic [COLOR_W-1:0]  first_r, first_nxt;
  logic [COLOR_W-1:0]  second_r, second_nxt;
  logic [REP_W-1:0]    rep_r, rep_nxt;
  logic                last_r;

  logic out_load, fire, last_word;

  assign out_load  = ~ovalid_r | out_ch.ready;
  assign fire      = ivalid_r & out_load;
  assign last_word = (irem_r == 3'd1);
  assign load_ok   = ~ivalid_r | (fire & last_word);

  always_comb begin
    if (imono_r) begin
      ibits_nxt  = {2'b0, ibits_r[ACC_W-1:2]};
      first_nxt  = ibits_r[0] ? COLOR_WHITE : COLOR_BLACK;
      second_nxt = ibits_r[1] ? COLOR_WHITE : COLOR_BLACK;
      rep_nxt    = REP_MONO;
    end else begin
      ibits_nxt  = {8'b0, ibits_r[ACC_W-1:8]};
      first_nxt  = palette(ibits_r[3:0]);
      second_nxt = palette(ibits_r[7:4]);
      rep_nxt    = REP_COLOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (item_v) begin
        ivalid_r <= 1'b1;
      end else if (fire && last_word) begin
        ivalid_r <= 1'b0;
      end
      if (fire) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_v) begin
      ibits_r <= item.bits;
      irem_r  <= item.words;
      imono_r <= item.mono;
    end else if (fire) begin
      ibits_r <= ibits_nxt;
      irem_r  <= irem_r - 3'd1;
    end
    if (fire) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      rep_r    <= rep_nxt;
      last_r   <= last_word;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.first_color  = first_r;
  assign out_ch.second_color = second_r;
  assign out_ch.repeat_each  = rep_r;
  assign out_ch.last_of_item = last_r;

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ivalid_r |-> (irem_r != '0))
    else $error("held item has no words left");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_word) |=> (ovalid_r && last_r))
    else $error("final word of item not marked");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ivalid_r && !out_load) |=> ($stable(ibits_r) && $stable(irem_r)))
    else $error("held item changed while output stalled");

endmodule

// ===== hdl/double_hires_pixel_serializer_core.sv =====
// ----------------------------------------------------------------------------
// double_hires_pixel_serializer_core: double hi-res pixel serializer
// Turns screen columns (aux + main byte) into two-pixel RGB333 words, either
// 4-bit palette colors or 1-bit white/black.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+----------------------------------------
//   in_ch    | in  | valid/ready      | aux_byte, main_byte, line_start
//   out_ch   | out | valid/ready      | first_color, second_color,
//            |     |                  | repeat_each, last_of_item
//   cfg      | in  | cfg_we (no wait) | cfg_wdata = monochrome_mode
//
// Rate: one word leaves per cycle while out_ch is not stalled; a column yields
//   7 words in monochrome mode and 1 or 2 in color mode, drained from the held
//   item by the single output register.
// Path: an accepted column is loaded into the item register, and its first word
//   then moves through the output register onto out_ch.
// A new column is accepted in the cycle the previous one's last word moves
//   to the output register, so columns stream with no gap.
// Reset (rst_n low, synchronous) clears the pending bits, the mode bit and
//   all valid flags; out_ch stalls simply hold the output and the held item.
// ----------------------------------------------------------------------------
module double_hires_pixel_serializer_core
  import dhr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  dhr_in_if.sink    in_ch,
  dhr_out_if.source out_ch
);

  // Column record passed from the accumulator to the emitter.
  item_t item;
  logic  item_v;
  logic  load_ok;   // emitter can take a new item this cycle

  // Front end: merges new bits with the leftover ones and decides the word
  // count; the leftover bits update at accept time, but a column is accepted
  // only while the emitter can take it (load_ok).
  dhr_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .load_ok   (load_ok),
    .item_v    (item_v),
    .item      (item)
  );

  // Back end: item register plus output register; palette lookup sits
  // between them.
  dhr_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_v  (item_v),
    .item    (item),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule
